// ----- design/timed_sequence_quote_table_unit_macros.svh -----
// Assertion macros used by the checker file of the quote table.
`ifndef TIMED_SEQUENCE_QUOTE_TABLE_UNIT_MACROS_SVH
`define TIMED_SEQUENCE_QUOTE_TABLE_UNIT_MACROS_SVH

// Condition holds in the same cycle as the trigger.
`define TSQT_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error("quote table check failed");

// Condition holds in the cycle after the trigger.
`define TSQT_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error("quote table check failed");

`endif

// ----- design/tsqt_pkg.sv -----
// Package of types and constants for the timed sequence quote table.
package tsqt_pkg;

  localparam int SLOTS     = 8;
  localparam int SLOT_W    = $clog2(SLOTS);
  localparam int QUOTE_MAX = 576;
  localparam int MIN_LEN   = 8;
  localparam int KEPT_W    = $clog2(QUOTE_MAX + 1);

  localparam int OP_W      = 2;
  localparam int SEQ_W     = 16;
  localparam int TIME_W    = 32;
  localparam int LEN_W     = 16;
  localparam int TMO_W     = 16;
  localparam int SLOT_OUT_W = 3;
  localparam int STORE_W   = 10;

  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  localparam logic [TMO_W-1:0] TIMEOUT_RESET = TMO_W'(10);

  typedef enum logic [OP_W-1:0] {
    OP_REMEMBER   = 2'd0,
    OP_FIND       = 2'd1,
    OP_INVALIDATE = 2'd2,
    OP_EXPIRE     = 2'd3
  } op_t;

  // Register index within the configuration map.
  typedef enum logic [0:0] {
    REG_TIMEOUT = 1'b0,
    REG_NONE    = 1'b1
  } reg_idx_t;

endpackage

// ----- design/tsqt_if.sv -----
// Channel interfaces for the quote table: operation words in, result words out.
interface tsqt_in_if;
  logic                          valid;
  logic                          ready;
  logic [tsqt_pkg::OP_W-1:0]     op;
  logic [tsqt_pkg::SEQ_W-1:0]    seq;
  logic [tsqt_pkg::TIME_W-1:0]   now;
  logic [tsqt_pkg::LEN_W-1:0]    length;
  logic [tsqt_pkg::LEN_W-1:0]    payload_offset;

  modport source (output valid, op, seq, now, length, payload_offset, input ready);
  modport sink   (input valid, op, seq, now, length, payload_offset, output ready);
endinterface

interface tsqt_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic [tsqt_pkg::SLOT_OUT_W-1:0]   slot;
  logic [tsqt_pkg::STORE_W-1:0]      stored_len;
  logic [tsqt_pkg::STORE_W-1:0]      stored_offset;

  modport source (output valid, hit, slot, stored_len, stored_offset, input ready);
  modport sink   (input valid, hit, slot, stored_len, stored_offset, output ready);
endinterface

// ----- design/timed_sequence_quote_table_unit.sv -----
// Top level of the timed sequence quote table: slot table, lookup and result register.
//
//   channel   direction  handshake          payload
//   in_ch     in         valid / ready      op, seq, now, length, payload_offset
//   out_ch    out        valid / ready      hit, slot, stored_len, stored_offset
//   cfg_*     in         APB write / read   timeout_seconds at byte address 0
//
// One word per cycle while results are taken: a word is registered on entry,
// then the eight slots are compared in parallel and the table and result
// register update together. Reset (rst_n, synchronous) clears the valid marks,
// the round-robin pointer and both stage valids; no clearing pass is needed.
// A stalled result holds the input stage, which then stops taking words.
module timed_sequence_quote_table_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  tsqt_in_if.sink                       in_ch,
  tsqt_out_if.source                    out_ch,
  input  logic                          cfg_psel,
  input  logic                          cfg_penable,
  input  logic                          cfg_pwrite,
  input  logic [tsqt_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [tsqt_pkg::DATA_W-1:0]   cfg_pwdata,
  output logic [tsqt_pkg::DATA_W-1:0]   cfg_prdata,
  output logic                          cfg_pready
);

  // Configuration register
  logic [tsqt_pkg::TMO_W-1:0] timeout_r;
  tsqt_pkg::reg_idx_t         cfg_idx;

  assign cfg_idx    = tsqt_pkg::reg_idx_t'(cfg_paddr[2]);
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= tsqt_pkg::TIMEOUT_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_idx == tsqt_pkg::REG_TIMEOUT) begin
      timeout_r <= cfg_pwdata[tsqt_pkg::TMO_W-1:0];
    end
  end

  always_comb begin
    case (cfg_idx)
      tsqt_pkg::REG_TIMEOUT: cfg_prdata = tsqt_pkg::DATA_W'(timeout_r);
      default:               cfg_prdata = '0;
    endcase
  end

  // Input stage
  logic                          in_v_r;
  tsqt_pkg::op_t                 op_r;
  logic [tsqt_pkg::SEQ_W-1:0]    seq_r;
  logic [tsqt_pkg::TIME_W-1:0]   now_r;
  logic [tsqt_pkg::LEN_W-1:0]    len_r;
  logic [tsqt_pkg::LEN_W-1:0]    off_r;

  logic out_v_r;
  logic fire;

  assign fire        = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      op_r  <= tsqt_pkg::op_t'(in_ch.op);
      seq_r <= in_ch.seq;
      now_r <= in_ch.now;
      len_r <= in_ch.length;
      off_r <= in_ch.payload_offset;
    end
  end

  // Slot table
  logic [tsqt_pkg::SLOTS-1:0]      valid_r, valid_nxt;
  logic [tsqt_pkg::SEQ_W-1:0]      seq_mem_r   [tsqt_pkg::SLOTS];
  logic [tsqt_pkg::TIME_W-1:0]     stamp_mem_r [tsqt_pkg::SLOTS];
  logic [tsqt_pkg::KEPT_W-1:0]     len_mem_r   [tsqt_pkg::SLOTS];
  logic [tsqt_pkg::KEPT_W-1:0]     off_mem_r   [tsqt_pkg::SLOTS];
  logic [tsqt_pkg::SLOT_W-1:0]     next_slot_r, next_slot_nxt;

  logic [tsqt_pkg::SLOTS-1:0] live;
  logic [tsqt_pkg::SLOTS-1:0] match;
  logic                       do_sweep;
  logic                       do_drop;
  logic                       bounds_ok;
  logic                       store;
  logic [tsqt_pkg::KEPT_W-1:0] kept;
  logic                       find_hit;
  logic [tsqt_pkg::SLOT_W-1:0] find_idx;

  assign do_sweep = op_r != tsqt_pkg::OP_INVALIDATE;
  assign do_drop  = op_r == tsqt_pkg::OP_REMEMBER || op_r == tsqt_pkg::OP_INVALIDATE;

  // An entry expires once now reaches stamp + timeout, except on an invalidate; the sum keeps its carry.
  always_comb begin
    for (int i = 0; i < tsqt_pkg::SLOTS; i++) begin
      live[i]  = valid_r[i] && !(do_sweep &&
                 ({1'b0, stamp_mem_r[i]} + (tsqt_pkg::TIME_W+1)'(timeout_r)
                  <= {1'b0, now_r}));
      match[i] = live[i] && seq_mem_r[i] == seq_r;
    end
  end

  assign bounds_ok = (off_r <= tsqt_pkg::LEN_W'(tsqt_pkg::QUOTE_MAX - tsqt_pkg::MIN_LEN)) &&
                     ({1'b0, len_r} >= {1'b0, off_r} + (tsqt_pkg::LEN_W+1)'(tsqt_pkg::MIN_LEN));
  assign store     = op_r == tsqt_pkg::OP_REMEMBER && bounds_ok;
  assign kept      = (len_r < tsqt_pkg::LEN_W'(tsqt_pkg::QUOTE_MAX)) ?
                     tsqt_pkg::KEPT_W'(len_r) : tsqt_pkg::KEPT_W'(tsqt_pkg::QUOTE_MAX);

  // Lowest matching slot wins, so scan from the top down.
  always_comb begin
    find_hit = 1'b0;
    find_idx = '0;
    for (int i = tsqt_pkg::SLOTS - 1; i >= 0; i--) begin
      if (match[i]) begin
        find_hit = 1'b1;
        find_idx = tsqt_pkg::SLOT_W'(i);
      end
    end
  end

  always_comb begin
    valid_nxt     = live & ~(match & {tsqt_pkg::SLOTS{do_drop}});
    next_slot_nxt = next_slot_r;
    if (store) begin
      valid_nxt[next_slot_r] = 1'b1;
      next_slot_nxt = (next_slot_r == tsqt_pkg::SLOT_W'(tsqt_pkg::SLOTS - 1)) ?
                      '0 : next_slot_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      next_slot_r <= '0;
    end else if (fire) begin
      valid_r     <= valid_nxt;
      next_slot_r <= next_slot_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store) begin
      seq_mem_r[next_slot_r]   <= seq_r;
      stamp_mem_r[next_slot_r] <= now_r;
      len_mem_r[next_slot_r]   <= kept;
      off_mem_r[next_slot_r]   <= tsqt_pkg::KEPT_W'(off_r);
    end
  end

  // Result register
  logic                              hit_nxt, hit_r;
  logic [tsqt_pkg::SLOT_W-1:0]       slot_nxt;
  logic [tsqt_pkg::KEPT_W-1:0]       rlen_nxt, roff_nxt;
  logic [tsqt_pkg::SLOT_OUT_W-1:0]   slot_r;
  logic [tsqt_pkg::STORE_W-1:0]      rlen_r, roff_r;

  always_comb begin
    hit_nxt  = 1'b0;
    slot_nxt = '0;
    rlen_nxt = '0;
    roff_nxt = '0;
    case (op_r)
      tsqt_pkg::OP_REMEMBER: begin
        if (bounds_ok) begin
          hit_nxt  = 1'b1;
          slot_nxt = next_slot_r;
          rlen_nxt = kept;
          roff_nxt = tsqt_pkg::KEPT_W'(off_r);
        end
      end
      tsqt_pkg::OP_FIND: begin
        if (find_hit) begin
          hit_nxt  = 1'b1;
          slot_nxt = find_idx;
          rlen_nxt = len_mem_r[find_idx];
          roff_nxt = off_mem_r[find_idx];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (fire) begin
      out_v_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      hit_r  <= hit_nxt;
      slot_r <= tsqt_pkg::SLOT_OUT_W'(slot_nxt);
      rlen_r <= tsqt_pkg::STORE_W'(rlen_nxt);
      roff_r <= tsqt_pkg::STORE_W'(roff_nxt);
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.hit           = hit_r;
  assign out_ch.slot          = slot_r;
  assign out_ch.stored_len    = rlen_r;
  assign out_ch.stored_offset = roff_r;

endmodule

// ----- design/tsqt_checker.sv -----
// Port-level checker for the quote table, bound to the top level.
`include "timed_sequence_quote_table_unit_macros.svh"

module tsqt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_hit,
  input logic [tsqt_pkg::SLOT_OUT_W-1:0]   out_slot,
  input logic [tsqt_pkg::STORE_W-1:0]      out_stored_len,
  input logic [tsqt_pkg::STORE_W-1:0]      out_stored_offset
);

  // A result word waiting on the sink stays offered.
  `TSQT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid)

  // A miss carries an all-zero payload.
  `TSQT_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, out_slot == '0 && out_stored_len == '0 && out_stored_offset == '0)

  // A kept entry always leaves room for the minimum quote after its offset.
  `TSQT_ASSERT_NOW(a_hit_room, out_valid && out_hit, ({1'b0, out_stored_offset} + (tsqt_pkg::STORE_W+1)'(tsqt_pkg::MIN_LEN)) <= {1'b0, out_stored_len})

endmodule

bind timed_sequence_quote_table_unit tsqt_checker u_tsqt_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_hit           (out_ch.hit),
  .out_slot          (out_ch.slot),
  .out_stored_len    (out_ch.stored_len),
  .out_stored_offset (out_ch.stored_offset)
);

// ----- test/testbench.sv -----
// Self-checking testbench for the timed sequence quote table unit.
`timescale 1ns / 1ps

module testbench;
  import tsqt_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_WORDS = 325;
  localparam int DIRECTED_ROWS = 25;

  typedef struct packed {
    op_t                op;
    logic [SEQ_W-1:0]   seq;
    logic [TIME_W-1:0]  now;
    logic [LEN_W-1:0]   length;
    logic [LEN_W-1:0]   payload_offset;
  } quote_req_t;

  typedef struct packed {
    logic                   hit;
    logic [SLOT_OUT_W-1:0]  slot;
    logic [STORE_W-1:0]     stored_len;
    logic [STORE_W-1:0]     stored_offset;
  } quote_res_t;

  typedef struct packed {
    quote_req_t  req;
    logic        typed;
    quote_res_t  want;
  } quote_row_t;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_MOSTLY, RX_COMB} rx_mode_t;

  localparam quote_res_t MISS = '0;

  logic clk;
  logic rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [ADDR_W-1:0] cfg_paddr;
  logic [DATA_W-1:0] cfg_pwdata;
  logic [DATA_W-1:0] cfg_prdata;
  logic              cfg_pready;

  tsqt_in_if  in_ch ();
  tsqt_out_if out_ch ();

  timed_sequence_quote_table_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Shadow of the table, kept in step with every accepted word.
  logic              table_valid [SLOTS];
  logic [SEQ_W-1:0]  table_seq   [SLOTS];
  logic [TIME_W-1:0] table_stamp [SLOTS];
  logic [9:0]        table_len   [SLOTS];
  logic [9:0]        table_off   [SLOTS];
  logic [SLOT_W-1:0] table_next;
  logic [TMO_W-1:0]  timeout_shadow;

  quote_res_t pending_results [$];
  int unsigned mismatches;
  int unsigned cycles;
  int unsigned burst_left;
  bit          sender_holding;
  logic [TIME_W-1:0] time_track;
  logic [SEQ_W-1:0]  seq_pool [8];
  rx_mode_t    rx_mode;
  int unsigned rx_tick;

  quote_row_t directed_rows [DIRECTED_ROWS] = '{
    '{'{OP_FIND,       16'h0000, 32'd0,        16'd0,     16'd0},     1'b1, MISS},
    '{'{OP_REMEMBER,   16'h0001, 32'd100,      16'hFFFF,  16'd0},     1'b1,
      '{1'b1, 3'd0, 10'd576, 10'd0}},
    '{'{OP_REMEMBER,   16'h0002, 32'd100,      16'd576,   16'd568},   1'b1,
      '{1'b1, 3'd1, 10'd576, 10'd568}},
    '{'{OP_REMEMBER,   16'h0003, 32'd100,      16'hFFFF,  16'd569},   1'b1, MISS},
    '{'{OP_REMEMBER,   16'h0004, 32'd100,      16'd7,     16'd0},     1'b1, MISS},
    '{'{OP_REMEMBER,   16'h0005, 32'd100,      16'd8,     16'd0},     1'b1,
      '{1'b1, 3'd2, 10'd8, 10'd0}},
    '{'{OP_REMEMBER,   16'h0006, 32'd100,      16'd0,     16'hFFFF},  1'b1, MISS},
    '{'{OP_FIND,       16'h0001, 32'd109,      16'd0,     16'd0},     1'b1,
      '{1'b1, 3'd0, 10'd576, 10'd0}},
    '{'{OP_FIND,       16'h0002, 32'd110,      16'd0,     16'd0},     1'b1, MISS},
    '{'{OP_REMEMBER,   16'hFFFF, 32'd110,      16'd300,   16'd20},    1'b1,
      '{1'b1, 3'd3, 10'd300, 10'd20}},
    '{'{OP_REMEMBER,   16'hFFFF, 32'd111,      16'd40,    16'd32},    1'b1,
      '{1'b1, 3'd4, 10'd40, 10'd32}},
    '{'{OP_FIND,       16'hFFFF, 32'd111,      16'd0,     16'd0},     1'b0, MISS},
    '{'{OP_INVALIDATE, 16'hFFFF, 32'd0,        16'd0,     16'd0},     1'b1, MISS},
    '{'{OP_FIND,       16'hFFFF, 32'd111,      16'd0,     16'd0},     1'b0, MISS},
    '{'{OP_EXPIRE,     16'h0000, 32'hFFFFFFFF, 16'd0,     16'd0},     1'b1, MISS},
    '{'{OP_FIND,       16'h0005, 32'hFFFFFFFF, 16'd0,     16'd0},     1'b0, MISS},
    '{'{OP_REMEMBER,   16'h0007, 32'hFFFFFFFF, 16'd1000,  16'd100},   1'b0, MISS},
    '{'{OP_FIND,       16'h0007, 32'hFFFFFFFF, 16'd0,     16'd0},     1'b0, MISS},
    '{'{OP_FIND,       16'h0007, 32'd0,        16'd0,     16'd0},     1'b0, MISS},
    '{'{OP_REMEMBER,   16'h0014, 32'd0,        16'd64,    16'd8},     1'b0, MISS},
    '{'{OP_REMEMBER,   16'h0015, 32'd0,        16'd64,    16'd8},     1'b0, MISS},
    '{'{OP_REMEMBER,   16'h0016, 32'd0,        16'd64,    16'd8},     1'b0, MISS},
    '{'{OP_FIND,       16'h0016, 32'd5,        16'd0,     16'd0},     1'b0, MISS},
    '{'{OP_REMEMBER,   16'h0016, 32'd5,        16'hFFFF,  16'd568},   1'b0, MISS},
    '{'{OP_INVALIDATE, 16'h0007, 32'hFFFFFFFF, 16'hFFFF,  16'hFFFF},  1'b1, MISS}
  };

  function automatic quote_res_t predict_quote(quote_req_t w);
    quote_res_t res;
    int unsigned idx;
    logic [9:0] kept;
    res = '0;
    // Expiry compares without wrap, so the sum is formed one bit wider.
    for (int i = 0; i < SLOTS; i++) begin
      if (w.op != OP_INVALIDATE && table_valid[i] &&
          ({1'b0, table_stamp[i]} + 33'(timeout_shadow)) <= {1'b0, w.now})
        table_valid[i] = 1'b0;
      if ((w.op == OP_REMEMBER || w.op == OP_INVALIDATE) && table_valid[i] &&
          table_seq[i] == w.seq)
        table_valid[i] = 1'b0;
    end
    case (w.op)
      OP_REMEMBER: begin
        if (!(int'(w.payload_offset) > QUOTE_MAX - MIN_LEN ||
              int'(w.length) < int'(w.payload_offset) + MIN_LEN)) begin
          idx = table_next;
          kept = (int'(w.length) < QUOTE_MAX) ? w.length[9:0] : 10'(QUOTE_MAX);
          table_stamp[idx] = w.now;
          table_seq[idx]   = w.seq;
          table_len[idx]   = kept;
          table_off[idx]   = w.payload_offset[9:0];
          table_valid[idx] = 1'b1;
          table_next       = SLOT_W'((idx + 1) % SLOTS);
          res.hit           = 1'b1;
          res.slot          = SLOT_OUT_W'(idx);
          res.stored_len    = kept;
          res.stored_offset = w.payload_offset[9:0];
        end
      end
      OP_FIND: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!res.hit && table_valid[i] && table_seq[i] == w.seq) begin
            res.hit           = 1'b1;
            res.slot          = SLOT_OUT_W'(i);
            res.stored_len    = table_len[i];
            res.stored_offset = table_off[i];
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // Mostly well-formed traffic around a slowly advancing clock, with a
  // small pool of sequence numbers so that finds and drops actually match.
  function automatic quote_req_t make_word();
    quote_req_t w;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 3)
      time_track = $urandom;
    else
      time_track = time_track + $urandom_range(0, int'(timeout_shadow) / 3 + 2);
    w.now = ($urandom_range(0, 19) == 0) ? 32'($urandom) : time_track;
    pick = $urandom_range(0, 99);
    if (pick < 40)      w.op = OP_REMEMBER;
    else if (pick < 75) w.op = OP_FIND;
    else if (pick < 88) w.op = OP_INVALIDATE;
    else                w.op = OP_EXPIRE;
    w.seq = ($urandom_range(0, 6) == 0) ? 16'($urandom) : seq_pool[$urandom_range(0, 7)];
    pick = $urandom_range(0, 99);
    if (pick < 75) begin
      w.payload_offset = 16'($urandom_range(0, QUOTE_MAX - MIN_LEN));
      w.length         = w.payload_offset + 16'(MIN_LEN) + 16'($urandom_range(0, 700));
    end else if (pick < 85) begin
      w.payload_offset = 16'($urandom_range(QUOTE_MAX - MIN_LEN - 2,
                                            QUOTE_MAX - MIN_LEN + 2));
      w.length         = w.payload_offset + 16'($urandom_range(MIN_LEN - 2, MIN_LEN + 1));
    end else begin
      w.payload_offset = 16'($urandom);
      w.length         = 16'($urandom);
    end
    return w;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at cycle %0d: %s got %0d, want %0d", cycles, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input quote_req_t w, input bit typed, input quote_res_t want);
    quote_res_t model_res;
    int unsigned gap;
    in_ch.op             <= w.op;
    in_ch.seq            <= w.seq;
    in_ch.now            <= w.now;
    in_ch.length         <= w.length;
    in_ch.payload_offset <= w.payload_offset;
    in_ch.valid          <= 1'b1;
    sender_holding = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    model_res = predict_quote(w);
    pending_results.push_back(typed ? want : model_res);
    burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        sender_holding = 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Lowers valid and waits until every expected result has come back.
  task automatic drain();
    if (sender_holding) begin
      in_ch.valid <= 1'b0;
      sender_holding = 1'b0;
    end
    while (pending_results.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Each transfer ends idle, with psel and penable low, so the next one starts on a fresh edge.
  task automatic cfg_write(input reg_idx_t idx, input logic [DATA_W-1:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= ADDR_W'(int'(idx) * 4);
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (idx == REG_TIMEOUT) timeout_shadow = data[TMO_W-1:0];
    @(posedge clk);
  endtask

  task automatic check_timeout();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= ADDR_W'(int'(REG_TIMEOUT) * 4);
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[TMO_W-1:0] !== timeout_shadow)
      report_mismatch("timeout readback", cfg_prdata[TMO_W-1:0], timeout_shadow);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // The receiver changes its stall habit at random among open, coin, mostly and comb modes.
  always @(posedge clk) begin
    rx_tick++;
    if (rx_tick % 50 == 0) rx_mode = rx_mode_t'($urandom_range(0, 3));
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_MOSTLY: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default:   out_ch.ready <= (rx_tick % 8) < 3;
      endcase
    end
  end

  always @(posedge clk) begin
    quote_res_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing pending", 1, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_ch.hit !== want.hit) report_mismatch("hit", out_ch.hit, want.hit);
        if (out_ch.slot !== want.slot) report_mismatch("slot", out_ch.slot, want.slot);
        if (out_ch.stored_len !== want.stored_len)
          report_mismatch("stored_len", out_ch.stored_len, want.stored_len);
        if (out_ch.stored_offset !== want.stored_offset)
          report_mismatch("stored_offset", out_ch.stored_offset, want.stored_offset);
      end
    end
  end

  initial begin
    logic [TMO_W-1:0] timeout_plan [6];
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_REMEMBER;
    in_ch.seq            = '0;
    in_ch.now            = '0;
    in_ch.length         = '0;
    in_ch.payload_offset = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    mismatches      = 0;
    cycles          = 0;
    rx_tick         = 0;
    rx_mode         = RX_OPEN;
    burst_left      = 1;
    sender_holding  = 1'b0;
    time_track      = '0;
    timeout_shadow  = TIMEOUT_RESET;
    table_next      = '0;
    for (int i = 0; i < SLOTS; i++) begin
      table_valid[i] = 1'b0;
      table_seq[i]   = '0;
      table_stamp[i] = '0;
      table_len[i]   = '0;
      table_off[i]   = '0;
    end
    timeout_plan = '{16'd0, 16'd1, 16'hFFFF, TIMEOUT_RESET,
                     16'($urandom_range(2, 200)), 16'd3};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_timeout();

    foreach (directed_rows[r])
      send_word(directed_rows[r].req, directed_rows[r].typed, directed_rows[r].want);
    drain();

    foreach (timeout_plan[p]) begin
      // Upper data bits are random; only the low half belongs to the register.
      cfg_write(REG_TIMEOUT, {16'($urandom), timeout_plan[p]});
      check_timeout();
      cfg_write(REG_NONE, 32'($urandom));
      check_timeout();
      seq_pool[0] = 16'h0000;
      seq_pool[1] = 16'hFFFF;
      for (int i = 2; i < 8; i++) seq_pool[i] = 16'($urandom);
      time_track = $urandom;
      repeat (PHASE_WORDS) send_word(make_word(), 1'b0, MISS);
      drain();
    end

    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/tsqt_pkg.sv
design/tsqt_if.sv
design/timed_sequence_quote_table_unit.sv
design/tsqt_checker.sv
test/testbench.sv
